### rtl/core/btff_pkg.sv
// Shared types, codes and constants of the boundary-tag first-fit allocator.
`timescale 1ns / 1ps
package btff_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned HEAP_BYTES_DEF = 65536;
    localparam logic [16:0] CHUNK_RESET    = 17'd4096;

    localparam word_t TAG_ALLOC    = 32'h0000_0001;
    localparam word_t PROLOGUE_TAG = 32'h0000_0009;
    localparam word_t MIN_BLOCK    = 32'd16;
    localparam word_t LIST_START   = 32'd8;
    localparam word_t INIT_BREAK   = 32'd16;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [16:0] req_size;
        logic [15:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SET_OOM, OP_SET_ZERO,
        OP_INIT_W0, OP_INIT_W1, OP_INIT_W2, OP_INIT_W3,
        OP_GROW_W0, OP_GROW_W1, OP_GROW_W2,
        OP_MRG_R0, OP_MRG_R1, OP_MRG_R2, OP_MRG_EVAL,
        OP_TAG_HDR, OP_TAG_FTR,
        OP_PLC_R, OP_PLC_EVAL, OP_PLC_ADV,
        OP_FREE_R, OP_FREE_SZ,
        OP_FIT_START, OP_FIT_EVAL, OP_FIT_FAIL,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_INIT_W0, S_INIT_W1, S_INIT_W2, S_INIT_W3,
        S_GROW_W0, S_GROW_W1, S_GROW_W2,
        S_MRG_R0, S_MRG_R1, S_MRG_R2, S_MRG_EVAL, S_MRG_HDR, S_MRG_FTR,
        S_FREE_R, S_FREE_SZ, S_FREE_HDR, S_FREE_FTR,
        S_FIT_START, S_FIT_EVAL, S_FIT_FAIL,
        S_PLC_R, S_PLC_EVAL, S_PLC_HDR, S_PLC_FTR, S_PLC_ADV, S_PLC_RHDR, S_PLC_RFTR,
        S_OOM, S_ZERO, S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   alloc;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       size_zero;
        logic       brk_zero;
        logic       init_fits;
        logic       free_ok;
        logic       both_alloc;
        logic       split;
        logic       fit_zero;
        logic       fit_hit;
        logic       fit_over;
        logic       grow_ok;
    } dp_stat_t;

endpackage

### rtl/core/btff_datapath.sv
// Datapath: heap memory, break and chunk registers, block address and size arithmetic.
`timescale 1ns / 1ps
module btff_datapath
    import btff_pkg::*;
#(
    parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  req_t        req,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output rsp_t        rsp
);

    localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
    localparam int unsigned IW         = $clog2(HEAP_WORDS);
    localparam int unsigned BW         = $clog2(HEAP_BYTES + 1);

    logic [31:0]   mem [HEAP_WORDS];
    logic [31:0]   mem_q;
    logic          oob_q;

    logic [16:0]   chunk_reg, chunk_next;
    logic [BW-1:0] brk_reg, brk_next;
    logic [1:0]    type_reg, type_next;
    logic [16:0]   size_reg, size_next;
    logic [15:0]   addr_reg, addr_next;
    word_t         bp_reg, bp_next;
    word_t         sz_reg, sz_next;
    word_t         nsz_reg, nsz_next;
    logic          nalloc_reg, nalloc_next;
    logic          split_reg, split_next;
    logic [17:0]   ext_reg, ext_next;
    logic [15:0]   res_reg, res_next;
    logic [1:0]    st_reg, st_next;
    rsp_t          rsp_reg, rsp_next;

    logic          mem_we, mem_re, mem_in;
    word_t         mem_addr, mem_wdata;
    logic [IW-1:0] mem_idx;

    word_t         tag, tsz, nb, brk_w, addr_w, heap_w, asz_w, ec_w, ext_w;
    logic [17:0]   chunk_up, ec, asz, ext_max;
    logic          split_now;

    // Derived sizes
    always_comb
    begin
        chunk_up  = ({1'b0, chunk_reg} + 18'd7) & 18'h3FFF8;
        ec        = (chunk_up < 18'd16) ? 18'd16 : chunk_up;
        asz       = (size_reg <= 17'd8) ? 18'd16 : (({1'b0, size_reg} + 18'd15) & 18'h3FFF8);
        ext_max   = (asz > ec) ? asz : ec;
        asz_w     = 32'(asz);
        ec_w      = 32'(ec);
        ext_w     = 32'(ext_reg);
        brk_w     = 32'(brk_reg);
        addr_w    = 32'(addr_reg);
        heap_w    = 32'(HEAP_BYTES);
        tag       = oob_q ? TAG_ALLOC : mem_q;
        tsz       = {tag[31:3], 3'b000};
        nb        = bp_reg + tsz;
        split_now = (tsz >= asz_w) && ((tsz - asz_w) >= MIN_BLOCK);
    end

    always_comb
    begin
        stat.req_type   = type_reg;
        stat.size_zero  = (size_reg == 17'd0);
        stat.brk_zero   = (brk_reg == '0);
        stat.init_fits  = ((INIT_BREAK + ec_w) <= heap_w);
        stat.free_ok    = (brk_reg != '0) && (addr_reg >= 16'd16) && (addr_reg[2:0] == 3'd0)
                          && (addr_w < brk_w);
        stat.both_alloc = tag[0] && nalloc_reg;
        stat.split      = split_reg;
        stat.fit_zero   = (tsz == 32'd0);
        stat.fit_hit    = (tsz >= asz_w) && !tag[0];
        stat.fit_over   = (nb > brk_w);
        stat.grow_ok    = !(32'(ext_max) > (heap_w - brk_w));
    end

    // Memory port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        case (cmd.op)
            OP_INIT_W0:   begin mem_we = 1'b1; mem_addr = 32'd0;  mem_wdata = 32'd0;        end
            OP_INIT_W1:   begin mem_we = 1'b1; mem_addr = 32'd4;  mem_wdata = PROLOGUE_TAG; end
            OP_INIT_W2:   begin mem_we = 1'b1; mem_addr = 32'd8;  mem_wdata = PROLOGUE_TAG; end
            OP_INIT_W3:   begin mem_we = 1'b1; mem_addr = 32'd12; mem_wdata = TAG_ALLOC;    end
            OP_GROW_W0:   begin mem_we = 1'b1; mem_addr = brk_w - 32'd4; mem_wdata = ext_w; end
            OP_GROW_W1:
            begin
                mem_we = 1'b1; mem_addr = bp_reg + ext_w - 32'd8; mem_wdata = ext_w;
            end
            OP_GROW_W2:
            begin
                mem_we = 1'b1; mem_addr = bp_reg + ext_w - 32'd4; mem_wdata = TAG_ALLOC;
            end
            OP_MRG_R0:    begin mem_re = 1'b1; mem_addr = bp_reg - 32'd4; end
            OP_MRG_R1:    begin mem_re = 1'b1; mem_addr = nb - 32'd4;     end
            OP_MRG_R2:    begin mem_re = 1'b1; mem_addr = bp_reg - 32'd8; end
            OP_TAG_HDR:
            begin
                mem_we = 1'b1; mem_addr = bp_reg - 32'd4; mem_wdata = sz_reg | 32'(cmd.alloc);
            end
            OP_TAG_FTR:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + sz_reg - 32'd8;
                mem_wdata = sz_reg | 32'(cmd.alloc);
            end
            OP_PLC_R:     begin mem_re = 1'b1; mem_addr = bp_reg - 32'd4; end
            OP_FREE_R:    begin mem_re = 1'b1; mem_addr = addr_w - 32'd4; end
            OP_FIT_START: begin mem_re = 1'b1; mem_addr = LIST_START - 32'd4; end
            OP_FIT_EVAL:  begin mem_re = 1'b1; mem_addr = nb - 32'd4; end
            default:      begin end
        endcase
        mem_in  = (mem_addr[31:2] < 30'(HEAP_WORDS));
        mem_idx = mem_addr[IW+1:2];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && mem_in)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_idx];
            oob_q <= !mem_in;
        end
    end

    // Register updates per operation
    always_comb
    begin
        chunk_next  = cfg_we ? cfg_wdata : chunk_reg;
        brk_next    = brk_reg;
        type_next   = type_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        bp_next     = bp_reg;
        sz_next     = sz_reg;
        nsz_next    = nsz_reg;
        nalloc_next = nalloc_reg;
        split_next  = split_reg;
        ext_next    = ext_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        rsp_next    = rsp_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                type_next = req.req_type;
                size_next = req.req_size;
                addr_next = req.block_addr;
                res_next  = '0;
                st_next   = ST_OK;
            end
            OP_SET_OOM:  st_next = ST_OOM;
            OP_SET_ZERO: st_next = ST_ZERO;
            OP_INIT_W3:
            begin
                brk_next = BW'(INIT_BREAK);
                ext_next = ec;
            end
            OP_GROW_W0:  bp_next = brk_w;
            OP_GROW_W2:  brk_next = brk_reg + BW'(ext_reg);
            OP_MRG_R1:   sz_next = tsz;
            OP_MRG_R2:
            begin
                nalloc_next = tag[0];
                nsz_next    = tsz;
            end
            OP_MRG_EVAL:
            begin
                if (tag[0] && !nalloc_reg)
                begin
                    sz_next = sz_reg + nsz_reg;
                end
                else if (!tag[0])
                begin
                    bp_next = bp_reg - tsz;
                    sz_next = sz_reg + tsz + (nalloc_reg ? 32'd0 : nsz_reg);
                end
            end
            OP_PLC_EVAL:
            begin
                split_next = split_now;
                res_next   = bp_reg[15:0];
                if (split_now)
                begin
                    sz_next  = asz_w;
                    nsz_next = tsz - asz_w;
                end
                else
                begin
                    sz_next = tsz;
                end
            end
            OP_PLC_ADV:
            begin
                bp_next = bp_reg + asz_w;
                sz_next = nsz_reg;
            end
            OP_FREE_R:    bp_next = addr_w;
            OP_FREE_SZ:   sz_next = tsz;
            OP_FIT_START: bp_next = LIST_START;
            OP_FIT_EVAL:
            begin
                if (!stat.fit_hit)
                begin
                    bp_next = nb;
                end
            end
            OP_FIT_FAIL:  ext_next = ext_max;
            OP_EMIT:
            begin
                rsp_next.result_addr = res_reg;
                rsp_next.status      = st_reg;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
            brk_reg   <= '0;
        end
        else
        begin
            chunk_reg <= chunk_next;
            brk_reg   <= brk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        bp_reg     <= bp_next;
        sz_reg     <= sz_next;
        nsz_reg    <= nsz_next;
        nalloc_reg <= nalloc_next;
        split_reg  <= split_next;
        ext_reg    <= ext_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

### rtl/core/btff_ctrl.sv
// Controller: sequences init, allocate and free through the datapath one step a cycle.
`timescale 1ns / 1ps
module btff_ctrl
    import btff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        emit;
    ctrl_state_t merge_exit;

    assign emit       = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign merge_exit = (stat.req_type == REQ_ALLOC) ? S_PLC_R : S_DONE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (req_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (stat.req_type)
                    REQ_INIT:  state_next = stat.init_fits ? S_INIT_W0 : S_OOM;
                    REQ_ALLOC:
                    begin
                        if (stat.size_zero)     state_next = S_ZERO;
                        else if (stat.brk_zero) state_next = S_OOM;
                        else                    state_next = S_FIT_START;
                    end
                    REQ_FREE:  state_next = stat.free_ok ? S_FREE_R : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_INIT_W0:   state_next = S_INIT_W1;
            S_INIT_W1:   state_next = S_INIT_W2;
            S_INIT_W2:   state_next = S_INIT_W3;
            S_INIT_W3:   state_next = S_GROW_W0;
            S_GROW_W0:   state_next = S_GROW_W1;
            S_GROW_W1:   state_next = S_GROW_W2;
            S_GROW_W2:   state_next = S_MRG_R0;
            S_MRG_R0:    state_next = S_MRG_R1;
            S_MRG_R1:    state_next = S_MRG_R2;
            S_MRG_R2:    state_next = S_MRG_EVAL;
            S_MRG_EVAL:  state_next = stat.both_alloc ? merge_exit : S_MRG_HDR;
            S_MRG_HDR:   state_next = S_MRG_FTR;
            S_MRG_FTR:   state_next = merge_exit;
            S_FREE_R:    state_next = S_FREE_SZ;
            S_FREE_SZ:   state_next = S_FREE_HDR;
            S_FREE_HDR:  state_next = S_FREE_FTR;
            S_FREE_FTR:  state_next = S_MRG_R0;
            S_FIT_START: state_next = S_FIT_EVAL;
            S_FIT_EVAL:
            begin
                if (stat.fit_zero)      state_next = S_FIT_FAIL;
                else if (stat.fit_hit)  state_next = S_PLC_R;
                else if (stat.fit_over) state_next = S_FIT_FAIL;
            end
            S_FIT_FAIL:  state_next = stat.grow_ok ? S_GROW_W0 : S_OOM;
            S_PLC_R:     state_next = S_PLC_EVAL;
            S_PLC_EVAL:  state_next = S_PLC_HDR;
            S_PLC_HDR:   state_next = S_PLC_FTR;
            S_PLC_FTR:   state_next = stat.split ? S_PLC_ADV : S_DONE;
            S_PLC_ADV:   state_next = S_PLC_RHDR;
            S_PLC_RHDR:  state_next = S_PLC_RFTR;
            S_PLC_RFTR:  state_next = S_DONE;
            S_OOM:       state_next = S_DONE;
            S_ZERO:      state_next = S_DONE;
            S_DONE:      if (emit) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.alloc = 1'b0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.op    = req_valid ? OP_LOAD : OP_NONE;
            end
            S_INIT_W0:   cmd.op = OP_INIT_W0;
            S_INIT_W1:   cmd.op = OP_INIT_W1;
            S_INIT_W2:   cmd.op = OP_INIT_W2;
            S_INIT_W3:   cmd.op = OP_INIT_W3;
            S_GROW_W0:   cmd.op = OP_GROW_W0;
            S_GROW_W1:   cmd.op = OP_GROW_W1;
            S_GROW_W2:   cmd.op = OP_GROW_W2;
            S_MRG_R0:    cmd.op = OP_MRG_R0;
            S_MRG_R1:    cmd.op = OP_MRG_R1;
            S_MRG_R2:    cmd.op = OP_MRG_R2;
            S_MRG_EVAL:  cmd.op = OP_MRG_EVAL;
            S_MRG_HDR, S_FREE_HDR, S_PLC_RHDR: cmd.op = OP_TAG_HDR;
            S_MRG_FTR, S_FREE_FTR, S_PLC_RFTR: cmd.op = OP_TAG_FTR;
            S_PLC_HDR:   begin cmd.op = OP_TAG_HDR; cmd.alloc = 1'b1; end
            S_PLC_FTR:   begin cmd.op = OP_TAG_FTR; cmd.alloc = 1'b1; end
            S_FREE_R:    cmd.op = OP_FREE_R;
            S_FREE_SZ:   cmd.op = OP_FREE_SZ;
            S_FIT_START: cmd.op = OP_FIT_START;
            S_FIT_EVAL:  cmd.op = OP_FIT_EVAL;
            S_FIT_FAIL:  cmd.op = OP_FIT_FAIL;
            S_PLC_R:     cmd.op = OP_PLC_R;
            S_PLC_EVAL:  cmd.op = OP_PLC_EVAL;
            S_PLC_ADV:   cmd.op = OP_PLC_ADV;
            S_OOM:       cmd.op = OP_SET_OOM;
            S_ZERO:      cmd.op = OP_SET_ZERO;
            S_DONE:      cmd.op = emit ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // Hold the result until taken; a new one loads as the old one leaves
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### rtl/core/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit heap allocator.
// Allocate walks the block headers, splits the block found when the rest is large enough,
//   and grows the heap when no free block fits and room remains.
// Throughput: one transaction at a time; the next can be taken in the cycle after the response
//   is loaded. The walk is bound by the single memory read port, one header per cycle.
// Reset: asynchronous active low; clears the break (no heap), chunk to 4096, FSM idle.
//   Heap memory is not cleared; every word read is laid down by init first.
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator
    import btff_pkg::*;
#(
    parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: one state per memory access or arithmetic step
    btff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: heap memory, tags, break and the result register
    btff_datapath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

`ifndef SYNTH
    // A failed or zero-size transaction never reports an address
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_OOM || rsp.status == ST_ZERO)
        |-> rsp.result_addr == 16'd0)
        else $error("failed transaction carries an address");

    // Only defined status codes are reported
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_OOM || rsp.status == ST_ZERO))
        else $error("undefined status code");

    // One transaction at a time: accept drops ready
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transaction accepted while busy");
`endif

endmodule
